// ===== design/tst_pkg.sv =====
// Shared types and constants of the touch stream tracker.
`timescale 1ns / 1ps
`default_nettype none

package tst_pkg;

  // Opcodes of an incoming request.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  // Phases of a pointer sample.
  localparam logic [1:0] PH_ADD    = 2'd0;
  localparam logic [1:0] PH_CHANGE = 2'd1;
  localparam logic [1:0] PH_REMOVE = 2'd2;
  localparam logic [1:0] PH_CANCEL = 2'd3;

  // Status codes carried by each result.
  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_MISSING       = 3'd1,
    ST_NOT_FINITE    = 3'd2,
    ST_DOUBLE_ADD    = 3'd3,
    ST_INVALID_START = 3'd4,
    ST_TABLE_FULL    = 3'd5,
    ST_CLOSED        = 3'd6,
    ST_CANCEL        = 3'd7
  } status_e;

  // Where the pointer and stream fields of a result come from.
  typedef enum logic [2:0] {
    SRC_REQ_ZERO = 3'd0,  // request pointer, stream number zero
    SRC_REQ_NEW  = 3'd1,  // request pointer, freshly issued stream number
    SRC_REQ_HIT  = 3'd2,  // request pointer, stream of the matching entry
    SRC_CANCEL   = 3'd3,  // pointer and stream of the lowest open entry
    SRC_ZERO     = 3'd4   // pointer and stream both zero
  } res_src_e;

  // One input request.
  typedef struct packed {
    logic        opcode;
    logic [31:0] pointer_key;
    logic [1:0]  phase;
    logic        fields_present;
    logic        position_finite;
  } tst_req_t;

  // One result.
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_pointer;
    logic [31:0] stream_number;
    logic        last;
  } tst_res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;        // capture the request and the key compare
    logic     add_entry;   // open a stream in the lowest free entry
    logic     drop_entry;  // close the matching entry
    logic     cancel_one;  // close the lowest open entry
    logic     emit;        // present a result in the next cycle
    status_e  st;
    res_src_e src;
  } tst_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_flush;
    logic present;
    logic finite;
    logic phase_add;
    logic phase_drop;
    logic hit;
    logic free_avail;
    logic open_any;
  } tst_stat_t;

endpackage

`default_nettype wire

// ===== design/touch_stream_tracker.sv =====
// Top level of the touch stream tracker: controller and datapath.
//
//  Channel   Ports                      Transfer
//  request   start, busy, req_i         taken at an edge with start high and busy low
//  result    res_valid_o, res_o         shown one cycle, taken at the edge ending it
//
// A sample first registers the request together with the parallel key compare
// over the table, then decides and updates the table.
// A flush or error then walks the open entries, one cancel result a cycle,
// and ends with the closing result.
// Each result appears in the cycle after the one that decided it.
// Reset empties the table at once; there is no clearing pass.
// The receiver cannot stall; results are never held back.
`timescale 1ns / 1ps
`default_nettype none

module touch_stream_tracker #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start,
  input  wire tst_pkg::tst_req_t req_i,
  output logic                busy,
  output logic                res_valid_o,
  output tst_pkg::tst_res_t      res_o
);

  tst_pkg::tst_cmd_t  cmd;
  tst_pkg::tst_stat_t stat;

  // Sequencing.
  tst_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // Table and result path.
  tst_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

// ===== design/tst_dp.sv =====
// Datapath of the touch stream tracker: request register, stream table and result register.
`timescale 1ns / 1ps
`default_nettype none

module tst_dp #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire tst_pkg::tst_req_t  req_i,
  input  wire tst_pkg::tst_cmd_t  cmd_i,
  output tst_pkg::tst_stat_t      stat_o,
  output logic                 res_valid_o,
  output tst_pkg::tst_res_t       res_o
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  tst_pkg::tst_req_t req_q;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [TABLE_DEPTH-1:0] hit_vec_q, hit_vec_d;
  logic [31:0] entry_pointer_q [TABLE_DEPTH];
  logic [31:0] entry_stream_q [TABLE_DEPTH];
  logic [31:0] next_stream_q, next_stream_d;
  logic        res_valid_q;
  tst_pkg::tst_res_t res_q, res_d;

  logic [TABLE_DEPTH-1:0] free_vec, free_oh, hit_oh, open_oh;
  logic [IDX_W-1:0] free_idx, hit_idx, open_idx, rd_idx;
  logic [31:0] rd_pointer, rd_stream;

  // Parallel key compare against the incoming pointer, registered with the request.
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_vec_d[i] = valid_q[i] && (entry_pointer_q[i] == req_i.pointer_key);
    end
  end

  // Lowest set bit of each search vector, as one-hot and as an index.
  assign free_vec = ~valid_q;
  assign free_oh  = free_vec & (~free_vec + TABLE_DEPTH'(1));
  assign hit_oh   = hit_vec_q & (~hit_vec_q + TABLE_DEPTH'(1));
  assign open_oh  = valid_q & (~valid_q + TABLE_DEPTH'(1));

  always_comb begin
    free_idx = '0;
    hit_idx  = '0;
    open_idx = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (free_oh[i]) free_idx = free_idx | IDX_W'(i);
      if (hit_oh[i])  hit_idx  = hit_idx  | IDX_W'(i);
      if (open_oh[i]) open_idx = open_idx | IDX_W'(i);
    end
  end

  // One shared read port into the table.
  assign rd_idx     = (cmd_i.src == tst_pkg::SRC_CANCEL) ? open_idx : hit_idx;
  assign rd_pointer = entry_pointer_q[rd_idx];
  assign rd_stream  = entry_stream_q[rd_idx];

  // Status towards the controller.
  always_comb begin
    stat_o.is_flush   = (req_q.opcode == tst_pkg::OP_FLUSH);
    stat_o.present    = req_q.fields_present;
    stat_o.finite     = req_q.position_finite;
    stat_o.phase_add  = (req_q.phase == tst_pkg::PH_ADD);
    stat_o.phase_drop = (req_q.phase == tst_pkg::PH_REMOVE) ||
                        (req_q.phase == tst_pkg::PH_CANCEL);
    stat_o.hit        = |hit_vec_q;
    stat_o.free_avail = |free_vec;
    stat_o.open_any   = |valid_q;
  end

  // Valid bits and the stream counter, which wraps past zero to one.
  always_comb begin
    valid_d       = valid_q;
    next_stream_d = next_stream_q;
    if (cmd_i.add_entry) begin
      valid_d       = valid_q | free_oh;
      next_stream_d = next_stream_q + 32'd1;
      if (next_stream_d == 32'd0) next_stream_d = 32'd1;
    end
    if (cmd_i.drop_entry) valid_d = valid_q & ~hit_oh;
    if (cmd_i.cancel_one) valid_d = valid_q & ~open_oh;
  end

  // Result fields selected by the controller.
  always_comb begin
    res_d.status = cmd_i.st;
    res_d.last   = (cmd_i.src != tst_pkg::SRC_CANCEL);
    case (cmd_i.src)
      tst_pkg::SRC_REQ_ZERO: begin
        res_d.out_pointer   = req_q.pointer_key;
        res_d.stream_number = 32'd0;
      end
      tst_pkg::SRC_REQ_NEW: begin
        res_d.out_pointer   = req_q.pointer_key;
        res_d.stream_number = next_stream_q;
      end
      tst_pkg::SRC_REQ_HIT: begin
        res_d.out_pointer   = req_q.pointer_key;
        res_d.stream_number = rd_stream;
      end
      tst_pkg::SRC_CANCEL: begin
        res_d.out_pointer   = rd_pointer;
        res_d.stream_number = rd_stream;
      end
      default: begin
        res_d.out_pointer   = 32'd0;
        res_d.stream_number = 32'd0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q       <= '0;
      next_stream_q <= 32'd1;
      res_valid_q   <= 1'b0;
    end else begin
      valid_q       <= valid_d;
      next_stream_q <= next_stream_d;
      res_valid_q   <= cmd_i.emit;
    end
  end

  // Payload registers and the table contents.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q     <= req_i;
      hit_vec_q <= hit_vec_d;
    end
    if (cmd_i.add_entry) begin
      entry_pointer_q[free_idx] <= req_q.pointer_key;
      entry_stream_q[free_idx]  <= next_stream_q;
    end
    if (cmd_i.emit) res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // The stream counter never issues zero.
  a_stream_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_stream_q != 32'd0)
    else $error("stream counter holds zero");

endmodule

`default_nettype wire

// ===== design/tst_ctrl.sv =====
// Controller of the touch stream tracker: sequences evaluation and the cancel walk.
`timescale 1ns / 1ps
`default_nettype none

module tst_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start_i,
  input  wire tst_pkg::tst_stat_t stat_i,
  output tst_pkg::tst_cmd_t       cmd_o,
  output logic                 busy_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_WALK = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   closed_q, closed_d;
  logic   fin_flush_q, fin_flush_d;
  tst_pkg::status_e fin_st_q, fin_st_d;

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    closed_d    = closed_q;
    fin_flush_d = fin_flush_q;
    fin_st_d    = fin_st_q;
    cmd_o       = '0;
    cmd_o.st    = tst_pkg::ST_OK;
    cmd_o.src   = tst_pkg::SRC_REQ_ZERO;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        state_d = S_IDLE;
        if (closed_q) begin
          cmd_o.emit = 1'b1;
          cmd_o.st   = tst_pkg::ST_CLOSED;
        end else if (stat_i.is_flush) begin
          fin_st_d    = tst_pkg::ST_OK;
          fin_flush_d = 1'b1;
          state_d     = S_WALK;
        end else if (!stat_i.present || !stat_i.finite ||
                     (stat_i.hit && stat_i.phase_add) ||
                     (!stat_i.hit && !stat_i.phase_add)) begin
          // Error: cancel all open streams, then report and close.
          fin_flush_d = 1'b0;
          closed_d    = 1'b1;
          state_d     = S_WALK;
          if (!stat_i.present)     fin_st_d = tst_pkg::ST_MISSING;
          else if (!stat_i.finite) fin_st_d = tst_pkg::ST_NOT_FINITE;
          else if (stat_i.hit)     fin_st_d = tst_pkg::ST_DOUBLE_ADD;
          else                     fin_st_d = tst_pkg::ST_INVALID_START;
        end else if (stat_i.phase_add) begin
          cmd_o.emit = 1'b1;
          if (stat_i.free_avail) begin
            cmd_o.add_entry = 1'b1;
            cmd_o.src       = tst_pkg::SRC_REQ_NEW;
          end else begin
            cmd_o.st = tst_pkg::ST_TABLE_FULL;
          end
        end else begin
          cmd_o.emit       = 1'b1;
          cmd_o.src        = tst_pkg::SRC_REQ_HIT;
          cmd_o.drop_entry = stat_i.phase_drop;
        end
      end
      S_WALK: begin
        cmd_o.emit = 1'b1;
        if (stat_i.open_any) begin
          cmd_o.cancel_one = 1'b1;
          cmd_o.st         = tst_pkg::ST_CANCEL;
          cmd_o.src        = tst_pkg::SRC_CANCEL;
        end else begin
          cmd_o.st  = fin_st_q;
          cmd_o.src = fin_flush_q ? tst_pkg::SRC_ZERO : tst_pkg::SRC_REQ_ZERO;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      closed_q    <= 1'b0;
      fin_flush_q <= 1'b0;
      fin_st_q    <= tst_pkg::ST_OK;
    end else begin
      state_q     <= state_d;
      closed_q    <= closed_d;
      fin_flush_q <= fin_flush_d;
      fin_st_q    <= fin_st_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  // Once closed, the block stays closed until reset.
  a_closed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(closed_q))
    else $error("closed flag cleared without reset");

  // A stream is only opened where a free entry exists.
  a_add_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.add_entry |-> stat_i.free_avail)
    else $error("add issued with the table full");

  // Only a matching entry is ever closed by a sample.
  a_drop_has_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.drop_entry |-> stat_i.hit)
    else $error("drop issued without a matching entry");

  // A request is taken only while idle.
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> !busy_o)
    else $error("request loaded while busy");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the touch stream tracker.
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH = 16;

  // One queued request with the idle cycles that precede it.
  typedef struct {
    tst_pkg::tst_req_t req;
    int       gap;
    bit       drain;  // hold off until every expected result has arrived
  } stim_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  tst_pkg::tst_req_t req = '0;
  logic     busy;
  logic     res_valid;
  tst_pkg::tst_res_t res;

  touch_stream_tracker #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_i      (req),
    .busy       (busy),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // Clock of 10 ns period.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Shadow copy of the stream table.
  logic        trk_valid [DEPTH];
  logic [31:0] trk_pointer [DEPTH];
  logic [31:0] trk_stream [DEPTH];
  logic [31:0] trk_next_stream;
  logic        trk_closed;

  tst_pkg::tst_res_t due_results[$];
  stim_t    sample_queue[$];

  int n_queued = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_errors = 0;
  int n_flushes = 0;
  int n_full = 0;
  int closing_status = -1;

  bit    have_item = 1'b0;
  stim_t cur_item;
  int    gap_left = 0;

  // Generation-side view of which pointers hold an open stream.
  logic [31:0] gen_open[$];
  bit          no_idle = 1'b0;

  task automatic push_result(input tst_pkg::status_e st, input logic [31:0] ptr,
                             input logic [31:0] sn, input logic lst);
    tst_pkg::tst_res_t r;
    r.status        = st;
    r.out_pointer   = ptr;
    r.stream_number = sn;
    r.last          = lst;
    due_results.push_back(r);
  endtask

  // Every open stream is cancelled in entry order and the table emptied.
  task automatic cancel_open_streams();
    for (int i = 0; i < DEPTH; i++) begin
      if (trk_valid[i]) begin
        push_result(tst_pkg::ST_CANCEL, trk_pointer[i], trk_stream[i], 1'b0);
        trk_valid[i] = 1'b0;
      end
    end
  endtask

  // A bad sample cancels everything and closes the block for good.
  task automatic reject_sample(input tst_pkg::status_e st, input logic [31:0] ptr);
    cancel_open_streams();
    push_result(st, ptr, 32'd0, 1'b1);
    trk_closed     = 1'b1;
    closing_status = int'(st);
  endtask

  // Works out the results of one accepted request and updates the shadow table.
  task automatic advance_tracker(input tst_pkg::tst_req_t r);
    int hit = -1;
    int free_slot = -1;
    if (trk_closed) begin
      push_result(tst_pkg::ST_CLOSED, r.pointer_key, 32'd0, 1'b1);
    end else if (r.opcode == tst_pkg::OP_FLUSH) begin
      n_flushes++;
      cancel_open_streams();
      push_result(tst_pkg::ST_OK, 32'd0, 32'd0, 1'b1);
    end else if (!r.fields_present) begin
      reject_sample(tst_pkg::ST_MISSING, r.pointer_key);
    end else if (!r.position_finite) begin
      reject_sample(tst_pkg::ST_NOT_FINITE, r.pointer_key);
    end else begin
      for (int i = 0; i < DEPTH; i++) begin
        if (trk_valid[i]) begin
          if (hit < 0 && trk_pointer[i] == r.pointer_key) hit = i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (hit >= 0 && r.phase == tst_pkg::PH_ADD) begin
        reject_sample(tst_pkg::ST_DOUBLE_ADD, r.pointer_key);
      end else if (hit < 0 && r.phase != tst_pkg::PH_ADD) begin
        reject_sample(tst_pkg::ST_INVALID_START, r.pointer_key);
      end else if (r.phase == tst_pkg::PH_ADD) begin
        if (free_slot < 0) begin
          n_full++;
          push_result(tst_pkg::ST_TABLE_FULL, r.pointer_key, 32'd0, 1'b1);
        end else begin
          trk_valid[free_slot]   = 1'b1;
          trk_pointer[free_slot] = r.pointer_key;
          trk_stream[free_slot]  = trk_next_stream;
          push_result(tst_pkg::ST_OK, r.pointer_key, trk_next_stream, 1'b1);
          trk_next_stream = trk_next_stream + 32'd1;
          if (trk_next_stream == 32'd0) trk_next_stream = 32'd1;
        end
      end else begin
        push_result(tst_pkg::ST_OK, r.pointer_key, trk_stream[hit], 1'b1);
        if (r.phase == tst_pkg::PH_REMOVE || r.phase == tst_pkg::PH_CANCEL)
          trk_valid[hit] = 1'b0;
      end
    end
  endtask

  // Driver: raises start after the drawn gap and holds it until accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      req   <= '0;
    end else begin
      if (start && !busy) begin
        advance_tracker(req);
        n_accepted++;
        have_item = 1'b0;
      end
      if (!have_item && sample_queue.size() != 0) begin
        cur_item  = sample_queue.pop_front();
        have_item = 1'b1;
        gap_left  = cur_item.gap;
      end
      if (!have_item) begin
        start <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cur_item.drain && due_results.size() != 0) begin
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        req   <= cur_item.req;
      end
    end
  end

  // Monitor: each strobed result is compared with the oldest expectation.
  always @(posedge clk_i) begin
    tst_pkg::tst_res_t exp_res;
    if (rst_ni && res_valid === 1'b1) begin
      if (due_results.size() == 0) begin
        if (n_errors < 10)
          $display("MISMATCH: unexpected result status %0d ptr %h stream %h last %0b",
                   res.status, res.out_pointer, res.stream_number, res.last);
        n_errors++;
      end else begin
        exp_res = due_results.pop_front();
        n_checked++;
        if (res.status !== exp_res.status || res.out_pointer !== exp_res.out_pointer ||
            res.stream_number !== exp_res.stream_number || res.last !== exp_res.last) begin
          if (n_errors < 10)
            $display({"MISMATCH at result %0d: expected status %0d ptr %h stream %h last %0b,",
                      " got status %0d ptr %h stream %h last %0b"},
                     n_checked, exp_res.status, exp_res.out_pointer,
                     exp_res.stream_number, exp_res.last, res.status,
                     res.out_pointer, res.stream_number, res.last);
          n_errors++;
        end
      end
    end
  end

  function automatic bit is_open(input logic [31:0] p);
    foreach (gen_open[i]) if (gen_open[i] == p) return 1'b1;
    return 1'b0;
  endfunction

  // A pointer with no open stream: mostly random, sometimes extreme or reused.
  function automatic logic [31:0] fresh_pointer();
    logic [31:0] p;
    do begin
      case ($urandom_range(0, 5))
        0:       p = 32'd0;
        1:       p = 32'hFFFF_FFFF;
        2:       p = 32'($urandom_range(1, 12));
        default: p = $urandom;
      endcase
    end while (is_open(p));
    return p;
  endfunction

  task automatic queue_item(input logic op, input logic [31:0] ptr, input logic [1:0] ph,
                            input logic present, input logic finite, input bit drain);
    stim_t s;
    s.req.opcode          = op;
    s.req.pointer_key     = ptr;
    s.req.phase           = ph;
    s.req.fields_present  = present;
    s.req.position_finite = finite;
    s.gap                 = no_idle ? 0 : $urandom_range(0, 12);
    s.drain               = drain;
    sample_queue.push_back(s);
    n_queued++;
  endtask

  task automatic gen_add(input logic [31:0] p);
    queue_item(tst_pkg::OP_SAMPLE, p, tst_pkg::PH_ADD, 1'b1, 1'b1, 1'b0);
    if (gen_open.size() < DEPTH) gen_open.push_back(p);
  endtask

  // Change, remove or cancel on an open stream.
  task automatic gen_touch(input int idx, input logic [1:0] ph);
    queue_item(tst_pkg::OP_SAMPLE, gen_open[idx], ph, 1'b1, 1'b1, 1'b0);
    if (ph == tst_pkg::PH_REMOVE || ph == tst_pkg::PH_CANCEL) gen_open.delete(idx);
  endtask

  task automatic gen_flush(input bit drain);
    queue_item(tst_pkg::OP_FLUSH, $urandom, 2'($urandom_range(0, 3)),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), drain);
    gen_open.delete();
  endtask

  // Reset, stimulus build-up and the end of the run.
  initial begin
    int sel;
    int kind;
    int top_up;
    for (int i = 0; i < DEPTH; i++) begin
      trk_valid[i]   = 1'b0;
      trk_pointer[i] = 32'd0;
      trk_stream[i]  = 32'd0;
    end
    trk_next_stream = 32'd1;
    trk_closed      = 1'b0;

    // Directed part: extreme pointers, every phase, a full table and a full flush.
    gen_flush(1'b0);
    gen_add(32'd0);
    gen_add(32'hFFFF_FFFF);
    gen_touch(0, tst_pkg::PH_CHANGE);
    gen_touch(1, tst_pkg::PH_CHANGE);
    gen_touch(0, tst_pkg::PH_REMOVE);
    gen_touch(0, tst_pkg::PH_CANCEL);
    gen_add(32'd0);
    gen_add(32'hFFFF_FFFF);
    while (gen_open.size() < DEPTH) gen_add(fresh_pointer());
    gen_add(fresh_pointer());
    gen_touch(5, tst_pkg::PH_CHANGE);
    gen_flush(1'b1);

    // Random part: mostly well-formed streams with random content.
    for (int n = 0; n < 130; n++) begin
      if ($urandom_range(0, 15) == 0) no_idle = !no_idle;
      sel = $urandom_range(0, 99);
      if (gen_open.size() == 0 || sel < 45) begin
        gen_add(fresh_pointer());
      end else if (sel < 73) begin
        gen_touch($urandom_range(0, gen_open.size() - 1), tst_pkg::PH_CHANGE);
      end else if (sel < 98) begin
        gen_touch($urandom_range(0, gen_open.size() - 1),
                  $urandom_range(0, 1) ? tst_pkg::PH_REMOVE : tst_pkg::PH_CANCEL);
      end else begin
        gen_flush($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 39) == 0) sample_queue[$].drain = 1'b1;
    end

    // Tail: open some more streams, then one bad sample closes the block.
    no_idle = 1'b0;
    top_up = $urandom_range(0, DEPTH - gen_open.size());
    for (int n = 0; n < top_up; n++) gen_add(fresh_pointer());
    kind = $urandom_range(0, 3);
    if (kind == 2 && gen_open.size() == 0) gen_add(fresh_pointer());
    case (kind)
      0: queue_item(tst_pkg::OP_SAMPLE, $urandom, 2'($urandom_range(0, 3)), 1'b0,
                    1'($urandom_range(0, 1)), 1'b0);
      1: queue_item(tst_pkg::OP_SAMPLE, $urandom, 2'($urandom_range(0, 3)),
                    1'b1, 1'b0, 1'b0);
      2: queue_item(tst_pkg::OP_SAMPLE, gen_open[$urandom_range(0, gen_open.size() - 1)],
                    tst_pkg::PH_ADD, 1'b1, 1'b1, 1'b0);
      default: queue_item(tst_pkg::OP_SAMPLE, fresh_pointer(), 2'($urandom_range(1, 3)),
                          1'b1, 1'b1, 1'b0);
    endcase
    gen_open.delete();

    // Once closed, every request is answered with the closed status.
    queue_item(tst_pkg::OP_SAMPLE, 32'd0, tst_pkg::PH_ADD, 1'b0, 1'b0, 1'b0);
    queue_item(tst_pkg::OP_FLUSH, 32'hFFFF_FFFF, tst_pkg::PH_CANCEL, 1'b1, 1'b1, 1'b0);
    for (int n = 0; n < 12; n++)
      queue_item(1'($urandom_range(0, 1)), $urandom, 2'($urandom_range(0, 3)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted != n_queued) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("summary: %0d requests accepted, %0d results checked, %0d flushes",
             n_accepted, n_checked, n_flushes);
    $display("summary: %0d adds refused on a full table, block closed by status %0d",
             n_full, closing_status);
    if (n_errors == 0 && due_results.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/tst_pkg.sv
design/tst_dp.sv
design/tst_ctrl.sv
design/touch_stream_tracker.sv
tb/testbench.sv
